// File: design/assert_macros.svh
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define LLI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lli assertion failed");

// consequent must hold in the cycle after the antecedent
`define LLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lli assertion failed");

`endif

// File: design/lli_pkg.sv
package lli_pkg;

    localparam int FIELD_W = 32;
    localparam int EPS_W   = 48;

    typedef enum logic [1:0] {
        ST_INTERSECT  = 2'd0,
        ST_PARALLEL   = 2'd1,
        ST_COINCIDENT = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] a_start_x;
        logic signed [FIELD_W-1:0] a_start_y;
        logic signed [FIELD_W-1:0] a_end_x;
        logic signed [FIELD_W-1:0] a_end_y;
        logic signed [FIELD_W-1:0] b_start_x;
        logic signed [FIELD_W-1:0] b_start_y;
        logic signed [FIELD_W-1:0] b_end_x;
        logic signed [FIELD_W-1:0] b_end_y;
    } in_word_t;

    typedef struct packed {
        status_t                   status;
        logic signed [FIELD_W-1:0] cross_x;
        logic signed [FIELD_W-1:0] cross_y;
        logic                      clipped;
    } out_word_t;

endpackage

// File: design/lli_front.sv
module lli_front
    import lli_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  in_word_t                          in_data,
    input  logic [EPS_W-1:0]                  epsilon,
    input  logic                              q_full,
    output logic                              in_stall,
    output logic                              push,
    output status_t                           st,
    output logic signed [COORD_WIDTH-1:0]     sx,
    output logic signed [COORD_WIDTH-1:0]     sy,
    output logic signed [COORD_WIDTH:0]       vx,
    output logic signed [COORD_WIDTH:0]       vy,
    output logic signed [2*COORD_WIDTH+2:0]   num_a,
    output logic signed [2*COORD_WIDTH+2:0]   den
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int PRW = 2 * W + 2;
    localparam int NW  = 2 * W + 3;
    localparam int CW  = (NW > EPS_W) ? NW : EPS_W;

    logic en;
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [W-1:0] ax1_reg, ay1_reg, ax2_reg, ay2_reg;
    logic signed [W-1:0] bx1_reg, by1_reg, bx2_reg, by2_reg;

    logic signed [DW-1:0] vx1_reg, vy1_reg, ux1_reg, uy1_reg, px1_reg, py1_reg;
    logic signed [W-1:0]  sx1_reg, sy1_reg;

    logic signed [PRW-1:0] m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    logic signed [DW-1:0]  vx2_reg, vy2_reg;
    logic signed [W-1:0]   sx2_reg, sy2_reg;

    logic signed [NW-1:0] na3_reg, nb3_reg, den3_reg;
    logic signed [DW-1:0] vx3_reg, vy3_reg;
    logic signed [W-1:0]  sx3_reg, sy3_reg;

    status_t              st4_reg;
    status_t              st_next;
    logic signed [NW-1:0] na4_reg, den4_reg;
    logic signed [DW-1:0] vx4_reg, vy4_reg;
    logic signed [W-1:0]  sx4_reg, sy4_reg;

    function automatic logic is_small(input logic [NW-1:0] v, input logic [EPS_W-1:0] e);
        logic [NW-1:0] m;
        logic [CW-1:0] mw;
        logic [CW-1:0] ew;
        m  = v[NW-1] ? (~v + 1'b1) : v;
        mw = CW'(m);
        ew = CW'(e);
        return (mw < ew) || (m == '0);
    endfunction

    assign en       = !(v4_reg && q_full);
    assign in_stall = !en;
    assign push     = v4_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // classification of the denominator and numerators
    always_comb
    begin
        if (is_small(den3_reg, epsilon))
        begin
            if (is_small(na3_reg, epsilon) && is_small(nb3_reg, epsilon))
            begin
                st_next = ST_COINCIDENT;
            end
            else
            begin
                st_next = ST_PARALLEL;
            end
        end
        else
        begin
            st_next = ST_INTERSECT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg <= in_data.a_start_x[W-1:0];
            ay1_reg <= in_data.a_start_y[W-1:0];
            ax2_reg <= in_data.a_end_x[W-1:0];
            ay2_reg <= in_data.a_end_y[W-1:0];
            bx1_reg <= in_data.b_start_x[W-1:0];
            by1_reg <= in_data.b_start_y[W-1:0];
            bx2_reg <= in_data.b_end_x[W-1:0];
            by2_reg <= in_data.b_end_y[W-1:0];

            vx1_reg <= {ax2_reg[W-1], ax2_reg} - {ax1_reg[W-1], ax1_reg};
            vy1_reg <= {ay2_reg[W-1], ay2_reg} - {ay1_reg[W-1], ay1_reg};
            ux1_reg <= {bx2_reg[W-1], bx2_reg} - {bx1_reg[W-1], bx1_reg};
            uy1_reg <= {by2_reg[W-1], by2_reg} - {by1_reg[W-1], by1_reg};
            px1_reg <= {ax1_reg[W-1], ax1_reg} - {bx1_reg[W-1], bx1_reg};
            py1_reg <= {ay1_reg[W-1], ay1_reg} - {by1_reg[W-1], by1_reg};
            sx1_reg <= ax1_reg;
            sy1_reg <= ay1_reg;

            m0_reg  <= ux1_reg * py1_reg;
            m1_reg  <= uy1_reg * px1_reg;
            m2_reg  <= vx1_reg * py1_reg;
            m3_reg  <= vy1_reg * px1_reg;
            m4_reg  <= uy1_reg * vx1_reg;
            m5_reg  <= ux1_reg * vy1_reg;
            vx2_reg <= vx1_reg;
            vy2_reg <= vy1_reg;
            sx2_reg <= sx1_reg;
            sy2_reg <= sy1_reg;

            na3_reg  <= {m0_reg[PRW-1], m0_reg} - {m1_reg[PRW-1], m1_reg};
            nb3_reg  <= {m2_reg[PRW-1], m2_reg} - {m3_reg[PRW-1], m3_reg};
            den3_reg <= {m4_reg[PRW-1], m4_reg} - {m5_reg[PRW-1], m5_reg};
            vx3_reg  <= vx2_reg;
            vy3_reg  <= vy2_reg;
            sx3_reg  <= sx2_reg;
            sy3_reg  <= sy2_reg;

            st4_reg  <= st_next;
            na4_reg  <= na3_reg;
            den4_reg <= den3_reg;
            vx4_reg  <= vx3_reg;
            vy4_reg  <= vy3_reg;
            sx4_reg  <= sx3_reg;
            sy4_reg  <= sy3_reg;
        end
    end

    assign st    = st4_reg;
    assign sx    = sx4_reg;
    assign sy    = sy4_reg;
    assign vx    = vx4_reg;
    assign vy    = vy4_reg;
    assign num_a = na4_reg;
    assign den   = den4_reg;

endmodule

// File: design/lli_queue.sv
module lli_queue
    import lli_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: design/lli_back.sv
module lli_back
    import lli_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  status_t                           q_st,
    input  logic signed [COORD_WIDTH-1:0]     q_sx,
    input  logic signed [COORD_WIDTH-1:0]     q_sy,
    input  logic signed [COORD_WIDTH:0]       q_vx,
    input  logic signed [COORD_WIDTH:0]       q_vy,
    input  logic signed [2*COORD_WIDTH+2:0]   q_num_a,
    input  logic signed [2*COORD_WIDTH+2:0]   q_den,
    output logic                              pop,
    input  logic                              out_stall,
    output logic                              out_valid,
    output out_word_t                         out_data
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int H  = W + 1;
    localparam int MW = 2 * W + 2;
    localparam int NW = 2 * W + 3;
    localparam int PW = 3 * W + 3;
    localparam int QW = W + 1;
    localparam int SW = W + 3;
    localparam int NS = W + 2;

    localparam logic signed [SW-1:0] MAXC   = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] MINC   = -MAXC - 1;
    localparam logic [W-1:0]         MAXC_W = MAXC[W-1:0];
    localparam logic [W-1:0]         MINC_W = MINC[W-1:0];
    localparam logic [QW-1:0]        Q_ONE  = QW'(1);

    logic en;

    logic                 v0_reg;
    status_t              st0_reg;
    logic signed [W-1:0]  sx0_reg, sy0_reg;
    logic signed [DW-1:0] vx0_reg, vy0_reg;
    logic signed [NW-1:0] na0_reg, den0_reg;

    logic [NW-1:0] na_neg, den_neg;
    logic [DW-1:0] vx_neg, vy_neg;

    logic                v1_reg;
    status_t             st1_reg;
    logic signed [W-1:0] sx1_reg, sy1_reg;
    logic [MW-1:0]       nm1_reg, dm1_reg;
    logic [DW-1:0]       dvx1_reg, dvy1_reg;
    logic                negx1_reg, negy1_reg;

    logic                v2_reg;
    status_t             st2_reg;
    logic signed [W-1:0] sx2_reg, sy2_reg;
    logic [MW-1:0]       dm2_reg;
    logic                negx2_reg, negy2_reg;
    logic [2*H-1:0]      plox2_reg, phix2_reg, ploy2_reg, phiy2_reg;

    // divider stages, index 0 holds the full products
    logic                v_reg    [NS+1];
    status_t             st_reg   [NS+1];
    logic signed [W-1:0] sx_reg   [NS+1];
    logic signed [W-1:0] sy_reg   [NS+1];
    logic [MW-1:0]       dm_reg   [NS+1];
    logic                negx_reg [NS+1];
    logic                negy_reg [NS+1];
    logic [PW-1:0]       remx_reg [NS+1];
    logic [PW-1:0]       remy_reg [NS+1];
    logic [QW-1:0]       qx_reg   [NS+1];
    logic [QW-1:0]       qy_reg   [NS+1];
    logic                ovfx_reg [NS+1];
    logic                ovfy_reg [NS+1];

    logic [PW-1:0] dsh [1:NS];
    logic          gex [1:NS];
    logic          gey [1:NS];

    logic                vf_reg;
    out_word_t           out_reg;
    out_word_t           out_next;
    logic [W:0]          resx, resy;
    logic signed [W-1:0] rx, ry;

    function automatic logic [W:0] sat_axis(input logic signed [W-1:0] s,
                                            input logic [QW-1:0] q,
                                            input logic ovf,
                                            input logic neg);
        logic signed [SW-1:0] qs;
        logic signed [SW-1:0] sum;
        logic [W:0]           r;
        qs  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        sum = SW'(s) + qs;
        if (ovf)
        begin
            r = {1'b1, (neg ? MINC_W : MAXC_W)};
        end
        else if (sum > MAXC)
        begin
            r = {1'b1, MAXC_W};
        end
        else if (sum < MINC)
        begin
            r = {1'b1, MINC_W};
        end
        else
        begin
            r = {1'b0, sum[W-1:0]};
        end
        return r;
    endfunction

    assign en  = !(vf_reg && out_stall);
    assign pop = en && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vf_reg <= 1'b0;
            for (int k = 0; k <= NS; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v0_reg   <= !q_empty;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v_reg[0] <= v2_reg;
            for (int k = 1; k <= NS; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
            vf_reg <= v_reg[NS];
        end
    end

    assign na_neg  = -na0_reg;
    assign den_neg = -den0_reg;
    assign vx_neg  = -vx0_reg;
    assign vy_neg  = -vy0_reg;

    // shifted divisor compare per quotient bit, the first stage only flags overflow
    always_comb
    begin
        for (int k = 1; k <= NS; k++)
        begin
            dsh[k] = PW'(dm_reg[k-1]) << (NS - k);
            gex[k] = remx_reg[k-1] >= dsh[k];
            gey[k] = remy_reg[k-1] >= dsh[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st0_reg  <= q_st;
            sx0_reg  <= q_sx;
            sy0_reg  <= q_sy;
            vx0_reg  <= q_vx;
            vy0_reg  <= q_vy;
            na0_reg  <= q_num_a;
            den0_reg <= q_den;

            st1_reg   <= st0_reg;
            sx1_reg   <= sx0_reg;
            sy1_reg   <= sy0_reg;
            nm1_reg   <= na0_reg[NW-1] ? na_neg[MW-1:0] : na0_reg[MW-1:0];
            dm1_reg   <= den0_reg[NW-1] ? den_neg[MW-1:0] : den0_reg[MW-1:0];
            dvx1_reg  <= vx0_reg[DW-1] ? vx_neg : vx0_reg;
            dvy1_reg  <= vy0_reg[DW-1] ? vy_neg : vy0_reg;
            negx1_reg <= na0_reg[NW-1] ^ den0_reg[NW-1] ^ vx0_reg[DW-1];
            negy1_reg <= na0_reg[NW-1] ^ den0_reg[NW-1] ^ vy0_reg[DW-1];

            st2_reg   <= st1_reg;
            sx2_reg   <= sx1_reg;
            sy2_reg   <= sy1_reg;
            dm2_reg   <= dm1_reg;
            negx2_reg <= negx1_reg;
            negy2_reg <= negy1_reg;
            plox2_reg <= nm1_reg[H-1:0] * dvx1_reg;
            phix2_reg <= nm1_reg[MW-1:H] * dvx1_reg;
            ploy2_reg <= nm1_reg[H-1:0] * dvy1_reg;
            phiy2_reg <= nm1_reg[MW-1:H] * dvy1_reg;

            st_reg[0]   <= st2_reg;
            sx_reg[0]   <= sx2_reg;
            sy_reg[0]   <= sy2_reg;
            dm_reg[0]   <= dm2_reg;
            negx_reg[0] <= negx2_reg;
            negy_reg[0] <= negy2_reg;
            remx_reg[0] <= PW'(plox2_reg) + (PW'(phix2_reg) << H);
            remy_reg[0] <= PW'(ploy2_reg) + (PW'(phiy2_reg) << H);
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            ovfx_reg[0] <= 1'b0;
            ovfy_reg[0] <= 1'b0;

            for (int k = 1; k <= NS; k++)
            begin
                st_reg[k]   <= st_reg[k-1];
                sx_reg[k]   <= sx_reg[k-1];
                sy_reg[k]   <= sy_reg[k-1];
                dm_reg[k]   <= dm_reg[k-1];
                negx_reg[k] <= negx_reg[k-1];
                negy_reg[k] <= negy_reg[k-1];
                if (k == 1)
                begin
                    ovfx_reg[k] <= gex[k];
                    ovfy_reg[k] <= gey[k];
                    remx_reg[k] <= remx_reg[k-1];
                    remy_reg[k] <= remy_reg[k-1];
                    qx_reg[k]   <= qx_reg[k-1];
                    qy_reg[k]   <= qy_reg[k-1];
                end
                else
                begin
                    ovfx_reg[k] <= ovfx_reg[k-1];
                    ovfy_reg[k] <= ovfy_reg[k-1];
                    remx_reg[k] <= gex[k] ? remx_reg[k-1] - dsh[k] : remx_reg[k-1];
                    remy_reg[k] <= gey[k] ? remy_reg[k-1] - dsh[k] : remy_reg[k-1];
                    qx_reg[k]   <= gex[k] ? (qx_reg[k-1] | (Q_ONE << (NS - k)))
                                          : qx_reg[k-1];
                    qy_reg[k]   <= gey[k] ? (qy_reg[k-1] | (Q_ONE << (NS - k)))
                                          : qy_reg[k-1];
                end
            end

            out_reg <= out_next;
        end
    end

    // add to the start point and saturate; zero point unless lines intersect
    always_comb
    begin
        resx = sat_axis(sx_reg[NS], qx_reg[NS], ovfx_reg[NS], negx_reg[NS]);
        resy = sat_axis(sy_reg[NS], qy_reg[NS], ovfy_reg[NS], negy_reg[NS]);
        rx   = resx[W-1:0];
        ry   = resy[W-1:0];
        out_next.status = st_reg[NS];
        if (st_reg[NS] == ST_INTERSECT)
        begin
            out_next.cross_x = FIELD_W'(rx);
            out_next.cross_y = FIELD_W'(ry);
            out_next.clipped = resx[W] | resy[W];
        end
        else
        begin
            out_next.cross_x = '0;
            out_next.cross_y = '0;
            out_next.clipped = 1'b0;
        end
    end

    assign out_valid = vf_reg;
    assign out_data  = out_reg;

endmodule

// File: design/line_line_intersection.sv
// channel   | handshake           | word
// ----------+---------------------+----------------------------------------
// in        | in_valid, in_stall  | in_data: two lines, eight Q16.16 coords
// out       | out_valid, out_stall| out_data: status, cross_x/y, clipped
// cfg       | cfg_wr_en           | cfg_wr_data: epsilon, Q16.32 units
//
// one word per clock sustained while out_stall stays low
// restoring divider: overflow stage, then one quotient bit a stage per axis
// reset empties both pipes and the queue, epsilon returns to 0.05
// out_stall freezes the back pipe; a four-word queue decouples the front
// in_stall rises when the queue is full and the front holds a finished word
module line_line_intersection
    import lli_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_word_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_word_t        out_data,
    input  logic             cfg_wr_en,
    input  logic [EPS_W-1:0] cfg_wr_data
);

    localparam int W  = COORD_WIDTH;
    localparam int NW = 2 * W + 3;
    localparam int QE = 2 + 2 * W + 2 * (W + 1) + 2 * NW;

    localparam logic [63:0] EPS_FULL = ((64'd1 << (2 * FRAC_BITS)) + 64'd10) / 64'd20;
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_FULL[EPS_W-1:0];

    logic [EPS_W-1:0] epsilon_reg;

    logic                 q_full, q_empty, push, pop;
    status_t              f_st;
    logic signed [W-1:0]  f_sx, f_sy, b_sx, b_sy;
    logic signed [W:0]    f_vx, f_vy, b_vx, b_vy;
    logic signed [NW-1:0] f_na, f_den, b_na, b_den;
    logic [1:0]           b_st_bits;
    logic [QE-1:0]        q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg <= EPS_RESET;
        end
        else if (cfg_wr_en)
        begin
            epsilon_reg <= cfg_wr_data;
        end
    end

    lli_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .epsilon  (epsilon_reg),
        .q_full   (q_full),
        .in_stall (in_stall),
        .push     (push),
        .st       (f_st),
        .sx       (f_sx),
        .sy       (f_sy),
        .vx       (f_vx),
        .vy       (f_vy),
        .num_a    (f_na),
        .den      (f_den)
    );

    assign q_wdata = {f_st, f_sx, f_sy, f_vx, f_vy, f_na, f_den};

    lli_queue #(
        .WIDTH (QE)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .pop   (pop),
        .full  (q_full),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    assign {b_st_bits, b_sx, b_sy, b_vx, b_vy, b_na, b_den} = q_rdata;

    lli_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_st      (status_t'(b_st_bits)),
        .q_sx      (b_sx),
        .q_sy      (b_sy),
        .q_vx      (b_vx),
        .q_vy      (b_vy),
        .q_num_a   (b_na),
        .q_den     (b_den),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// File: design/lli_checker.sv
`include "assert_macros.svh"

module lli_checker
    import lli_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_stall,
    input out_word_t        out_data
);

    localparam logic signed [FIELD_W-1:0] MAXC =
        FIELD_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [FIELD_W-1:0] MINC = -MAXC - 1;

    logic no_point;
    logic on_bound;
    logic in_range;

    assign no_point = (out_data.cross_x == '0) && (out_data.cross_y == '0)
                      && !out_data.clipped;
    assign on_bound = (out_data.cross_x == MAXC) || (out_data.cross_x == MINC)
                      || (out_data.cross_y == MAXC) || (out_data.cross_y == MINC);
    assign in_range = (out_data.cross_x <= MAXC) && (out_data.cross_x >= MINC)
                      && (out_data.cross_y <= MAXC) && (out_data.cross_y >= MINC);

    // no point for parallel or coincident lines
    `LLI_ASSERT(a_no_point, clk, rst_n, out_valid && out_data.status != ST_INTERSECT |-> no_point)

    // a clipped word sits on the coordinate range bound
    `LLI_ASSERT(a_clip_bound, clk, rst_n, out_valid && out_data.clipped |-> on_bound)

    // results stay in the coordinate range
    `LLI_ASSERT(a_range, clk, rst_n, out_valid |-> in_range)

    `LLI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind line_line_intersection lli_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lli_checker (.*);

// File: test/line_line_intersection_tb.sv
`timescale 1ns / 100ps

class cross_board;
    lli_pkg::out_word_t pending[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    function void note(lli_pkg::out_word_t w);
        pending.push_back(w);
    endfunction

    function void check(lli_pkg::out_word_t got);
        lli_pkg::out_word_t want;
        if (pending.size() == 0) begin
            $error("unexpected word status=%0d", got.status);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
        end
        if (got.cross_x !== want.cross_x) begin
            $error("cross_x expected %0d actual %0d", want.cross_x, got.cross_x);
            errors++;
        end
        if (got.cross_y !== want.cross_y) begin
            $error("cross_y expected %0d actual %0d", want.cross_y, got.cross_y);
            errors++;
        end
        if (got.clipped !== want.clipped) begin
            $error("clipped expected %0d actual %0d", want.clipped, got.clipped);
            errors++;
        end
    endfunction
endclass

module line_line_intersection_tb;
    import lli_pkg::*;

    localparam longint LIMIT = 400000;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    in_word_t in_data = '0;
    logic out_valid;
    logic out_stall = 0;
    out_word_t out_data;
    logic cfg_wr_en = 0;
    logic [EPS_W-1:0] cfg_wr_data = '0;

    logic [EPS_W-1:0] eps_now = 48'd214748365;
    cross_board board = new();
    int idle_pct = 12;
    bit hold_rx = 0;
    longint cycles = 0;

    line_line_intersection dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #5 clk = ~clk;

    function automatic bit is_tiny(logic signed [127:0] v);
        logic [127:0] m;
        m = v < 0 ? -v : v;
        return m == 0 || m < {80'd0, eps_now};
    endfunction

    function automatic logic signed [31:0] solve_axis(logic signed [63:0] start,
        logic signed [127:0] num, logic signed [63:0] dir, logic signed [127:0] den,
        ref bit clip);
        logic [127:0] nm, dm, q;
        logic [63:0] dv;
        logic signed [63:0] qs, s;
        bit neg;
        nm = num < 0 ? -num : num;
        dm = den < 0 ? -den : den;
        dv = dir < 0 ? -dir : dir;
        neg = ((num < 0) != (den < 0)) != (dir < 0);
        q = (nm * {64'd0, dv}) / dm;
        if (q > (128'd1 << 40)) q = 128'd1 << 40;
        qs = neg ? -$signed(q[63:0]) : $signed(q[63:0]);
        s = start + qs;
        if (s > 64'sd2147483647) begin s = 64'sd2147483647; clip = 1; end
        if (s < -64'sd2147483648) begin s = -64'sd2147483648; clip = 1; end
        return s[31:0];
    endfunction

    function automatic out_word_t predict(in_word_t w);
        logic signed [63:0] ax, ay, vx, vy, ux, uy, px, py;
        logic signed [127:0] na, nb, dn;
        out_word_t r;
        bit clip;
        clip = 0;
        ax = w.a_start_x; ay = w.a_start_y;
        vx = 64'(w.a_end_x) - ax; vy = 64'(w.a_end_y) - ay;
        ux = 64'(w.b_end_x) - 64'(w.b_start_x); uy = 64'(w.b_end_y) - 64'(w.b_start_y);
        px = ax - 64'(w.b_start_x); py = ay - 64'(w.b_start_y);
        na = 128'(ux) * 128'(py) - 128'(uy) * 128'(px);
        nb = 128'(vx) * 128'(py) - 128'(vy) * 128'(px);
        dn = 128'(uy) * 128'(vx) - 128'(ux) * 128'(vy);
        r = '0;
        if (is_tiny(dn)) begin
            r.status = (is_tiny(na) && is_tiny(nb)) ? ST_COINCIDENT : ST_PARALLEL;
        end else begin
            r.status = ST_INTERSECT;
            r.cross_x = solve_axis(ax, na, vx, dn, clip);
            r.cross_y = solve_axis(ay, na, vy, dn, clip);
            r.clipped = clip;
        end
        return r;
    endfunction

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (rst_n && in_valid && !in_stall) board.note(predict(in_data));
        if (rst_n && out_valid && !out_stall) board.check(out_data);
    end

    always @(negedge clk) begin
        out_stall <= hold_rx || ($urandom_range(99) < idle_pct);
    end

    task automatic send(in_word_t w);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_data <= w;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic set_eps(logic [EPS_W-1:0] e);
        drain();
        cfg_wr_en <= 1;
        cfg_wr_data <= e;
        @(negedge clk);
        cfg_wr_en <= 0;
        eps_now = e;
    endtask

    function automatic logic [31:0] pick();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
            2: return $signed($urandom_range(2000)) - 1000;
            default: return ($signed($urandom_range(400)) - 200) <<< 16;
        endcase
    endfunction

    function automatic in_word_t rand_word();
        in_word_t w;
        int k;
        logic signed [31:0] dx, dy;
        k = $urandom_range(9);
        w = {pick(), pick(), pick(), pick(), pick(), pick(), pick(), pick()};
        if (k == 0) begin
            // parallel, sometimes collinear
            dx = w.a_end_x - w.a_start_x;
            dy = w.a_end_y - w.a_start_y;
            w.b_end_x = w.b_start_x + dx;
            w.b_end_y = w.b_start_y + dy;
            if ($urandom_range(1)) begin
                w.b_start_x = w.a_start_x; w.b_start_y = w.a_start_y;
                w.b_end_x = w.a_end_x; w.b_end_y = w.a_end_y;
            end
        end else if (k == 1) begin
            w = {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        end
        return w;
    endfunction

    initial begin
        in_word_t w;
        logic [EPS_W-1:0] eps_list[4];
        eps_list = '{48'd0, 48'hffff_ffff_ffff, 48'd1 << 20, 48'd214748365};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        // directed
        send('0);
        send({32'sh0, 32'sh0, 32'sh10000, 32'sh10000, 32'sh0, 32'sh10000, 32'sh10000, 32'sh0});
        send({32'sh0, 32'sh0, 32'sh10000, 32'sh0, 32'sh0, 32'sh10000, 32'sh10000, 32'sh10000});
        send({32'sh0, 32'sh0, 32'sh10000, 32'sh0, 32'sh20000, 32'sh0, 32'sh30000, 32'sh0});
        send({32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000});
        send({32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
              32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff});
        send({32'h7fffffff, 32'h0, 32'h80000000, 32'h1, 32'h0, 32'h0, 32'h1, 32'h0});
        send({32'h0, 32'h0, 32'h1, 32'h1, 32'h0, 32'h1, 32'h1, 32'h0});
        send({32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
              32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
        send({32'h7fff0000, 32'h0, 32'h7fff0001, 32'h1, 32'h0, 32'h0, 32'h1, 32'h0});
        for (int p = 0; p < 4; p++) begin
            set_eps(eps_list[p]);
            send({32'h0, 32'h0, 32'h1, 32'h1, 32'h0, 32'h1, 32'h1, 32'h0});
            send({32'sh0, 32'sh0, 32'sh10000, 32'sh10000, 32'sh0, 32'sh10000, 32'sh10000, 32'sh0});
            if (p == 1) idle_pct = 0;
            for (int i = 0; i < 480; i++) begin
                if (p == 2 && i == 100) begin
                    fork
                        begin
                            hold_rx = 1;
                            repeat (200) @(negedge clk);
                            hold_rx = 0;
                        end
                    join_none
                end
                if (p == 3 && i == 240) drain();
                w = rand_word();
                send(w);
            end
            idle_pct = 12;
        end
        drain();
        if (board.errors == 0 && board.pending.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: files.f
+incdir+design
design/lli_pkg.sv
design/lli_front.sv
design/lli_queue.sv
design/lli_back.sv
design/line_line_intersection.sv
design/lli_checker.sv
test/line_line_intersection_tb.sv
